>>> rtl/scheduled_date_calculator_macros.svh
// ----------------------------------------------------------------------------
// Scheduled date calculator assertion macros
// Concurrent check wrappers on clk with rst as the disable; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SCHEDULED_DATE_CALCULATOR_MACROS_SVH
`define SCHEDULED_DATE_CALCULATOR_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset
`define SDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition is followed in the next cycle by an outcome
`define SDC_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);
`else
`define SDC_ASSERT(lbl, prop, msg)
`define SDC_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif
`endif

>>> rtl/sdc_pkg.sv
// ----------------------------------------------------------------------------
// Scheduled date calculator package
// Word types, mode codes, queue sizes and calendar helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

  // Request modes
  localparam logic [2:0] MODE_TIME      = 3'd0;
  localparam logic [2:0] MODE_TIME_WEEK = 3'd1;
  localparam logic [2:0] MODE_WDAY      = 3'd2;
  localparam logic [2:0] MODE_WDAY_WEEK = 3'd3;
  localparam logic [2:0] MODE_MDAY      = 3'd4;

  // Calendar constants
  localparam int MONTHS       = 12;
  localparam int YEAR_OFFSET  = 399;   // 400-year shift keeps the weekday sum positive

  // Reciprocal multipliers: v / 100 exact for v < 2^15, v / 7 exact for v < 2^15
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [14:0] DIV7_MUL     = 15'd18725;
  localparam int          DIV7_SHIFT   = 17;

  // Queue sizes (powers of two, pointers wrap naturally)
  localparam int MID_DEPTH = 4;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int MID_CW    = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  // Input word
  typedef struct packed {
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_mday;
    logic [8:0]  cur_yday;
    logic [2:0]  cur_wday;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_min;
    logic [4:0]  req_hour;
    logic [5:0]  req_min;
    logic [2:0]  mode;
    logic [3:0]  req_index;
    logic [4:0]  req_mday;
  } req_word_t;

  // Result word
  typedef struct packed {
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_mday;
    logic [8:0]  out_yday;
    logic [2:0]  out_wday;
  } sched_word_t;

  // Classified word between the front end and the back end
  typedef struct packed {
    logic [13:0] year0;       // current year
    logic [13:0] year1;       // next year, wrapped
    logic [7:0]  cent0;       // year0 / 100
    logic [7:0]  cent1;       // year1 / 100
    logic        month_mode;
    logic        next_year;   // month-day date already passed this year
    logic [3:0]  mon;         // clamped month (month mode)
    logic [4:0]  mday;        // clamped day (month mode)
    logic [8:0]  cyday;       // current day of year, unclamped
    logic [3:0]  inc;         // days to step forward (other modes)
    logic [2:0]  wday;        // result weekday (other modes)
  } job_word_t;

  // Quotient by 100 through a reciprocal multiply
  function automatic logic [7:0] div100(input logic [14:0] v);
    logic [27:0] prod;
    prod = 28'(v) * 28'(DIV100_MUL);
    return 8'(prod >> DIV100_SHIFT);
  endfunction

  // Gregorian leap test from the year and its hundreds quotient
  function automatic logic is_leap(input logic [13:0] y, input logic [7:0] cent);
    logic [14:0] rem;
    rem = 15'(y) - 15'(cent) * 15'd100;
    return (y[1:0] == 2'd0) && ((rem != 15'd0) || (cent[1:0] == 2'd0));
  endfunction

  // Day of year on which a month starts
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    unique case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      default: base = 9'd334;
    endcase
    return base + (((leap) && (m >= 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

`default_nettype wire

>>> rtl/sdc_front.sv
// ----------------------------------------------------------------------------
// Scheduled date calculator front end
// Decodes the mode, settles time and date comparisons and the day step.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_front (
  input  sdc_pkg::req_word_t request,
  input  logic               push,
  input  logic               full,
  output logic               wr_en,
  output sdc_pkg::job_word_t job
);
  import sdc_pkg::*;

  logic [13:0] year1;
  logic        month_mode;
  logic        wday_mode;
  logic        week_mode;
  logic        time_late;
  logic [3:0]  mon_c;
  logic [4:0]  mday_c;
  logic [2:0]  cw;
  logic [2:0]  w;
  logic [2:0]  delta;
  logic [3:0]  inc;
  logic [2:0]  wday;

  // Accept a word whenever the queue has room
  assign wr_en = push && !full;

  // Decode the mode; unused codes behave as time only
  always_comb begin
    month_mode = 1'b0;
    wday_mode  = 1'b0;
    week_mode  = 1'b0;
    unique case (request.mode)
      MODE_MDAY:      month_mode = 1'b1;
      MODE_TIME_WEEK: week_mode  = 1'b1;
      MODE_WDAY:      wday_mode  = 1'b1;
      MODE_WDAY_WEEK: begin
        wday_mode = 1'b1;
        week_mode = 1'b1;
      end
      default: ;
    endcase
  end

  // Classify time, weekday and month-day
  always_comb begin
    year1     = request.cur_year + 14'd1;
    time_late = (request.req_hour < request.cur_hour) ||
                ((request.req_hour == request.cur_hour) &&
                 (request.req_min <= request.cur_min));
    mon_c  = (request.req_index > 4'd11) ? 4'd11 : request.req_index;
    mday_c = (request.req_mday == 5'd0) ? 5'd1 : request.req_mday;
    cw     = (request.cur_wday == 3'd7) ? 3'd0 : request.cur_wday;
    // fold the weekday index into 0..6
    if (request.req_index >= 4'd14) begin
      w = 3'(request.req_index - 4'd14);
    end else if (request.req_index >= 4'd7) begin
      w = 3'(request.req_index - 4'd7);
    end else begin
      w = 3'(request.req_index);
    end
    delta = (w >= cw) ? (w - cw) : 3'(4'(w) + 4'd7 - 4'(cw));
    // step forward in days and the weekday that lands there
    if (wday_mode) begin
      wday = w;
      inc  = 4'(delta) + (((time_late && (w == cw)) || week_mode) ? 4'd7 : 4'd0);
    end else if (week_mode) begin
      wday = cw;
      inc  = 4'd7;
    end else if (time_late) begin
      wday = (cw == 3'd6) ? 3'd0 : cw + 3'd1;
      inc  = 4'd1;
    end else begin
      wday = cw;
      inc  = 4'd0;
    end
  end

  // Build the classified word
  always_comb begin
    job.year0      = request.cur_year;
    job.year1      = year1;
    job.cent0      = div100(15'(request.cur_year));
    job.cent1      = div100(15'(year1));
    job.month_mode = month_mode;
    job.next_year  = (mon_c < request.cur_month) ||
                     ((mon_c == request.cur_month) && (mday_c < request.cur_mday));
    job.mon        = mon_c;
    job.mday       = mday_c;
    job.cyday      = request.cur_yday;
    job.inc        = inc;
    job.wday       = wday;
  end

endmodule

`default_nettype wire

>>> rtl/sdc_mid_queue.sv
// ----------------------------------------------------------------------------
// Scheduled date calculator middle queue
// Short register queue of classified words between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scheduled_date_calculator_macros.svh"

module sdc_mid_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  sdc_pkg::job_word_t wr_word,
  input  logic               rd_en,
  output sdc_pkg::job_word_t rd_word,
  output logic               full,
  output logic               empty
);
  import sdc_pkg::*;

  job_word_t         mem [MID_DEPTH];
  logic [MID_AW-1:0] wr_ptr;
  logic [MID_AW-1:0] rd_ptr;
  logic [MID_CW-1:0] count;
  logic [MID_CW-1:0] count_next;

  assign full    = (count == MID_CW'(MID_DEPTH));
  assign empty   = (count == '0);
  assign rd_word = mem[rd_ptr];

  // Track occupancy
  always_comb begin
    count_next = count;
    if (wr_en && !rd_en) begin
      count_next = count + MID_CW'(1);
    end else if (!wr_en && rd_en) begin
      count_next = count - MID_CW'(1);
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + MID_AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + MID_AW'(1);
      end
      count <= count_next;
    end
  end

  // Store words
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  `SDC_ASSERT(a_mid_count_range, count <= MID_CW'(MID_DEPTH), "mid queue count out of range")
  `SDC_ASSERT(a_mid_no_overflow, !(wr_en && full), "mid queue written while full")
  `SDC_ASSERT(a_mid_no_underflow, !(rd_en && empty), "mid queue read while empty")
  `SDC_ASSERT_NEXT(a_mid_grow, wr_en && !rd_en, count == $past(count) + MID_CW'(1), "mid queue count did not grow")

endmodule

`default_nettype wire

>>> rtl/sdc_back.sv
// ----------------------------------------------------------------------------
// Scheduled date calculator back end
// Three-stage date pipeline (year and day of year, month split and century
// quotient, weekday residue) feeding a result queue under credit control.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scheduled_date_calculator_macros.svh"

module sdc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  sdc_pkg::job_word_t   job,
  output logic                 job_pop,
  input  logic                 pop,
  output logic                 empty,
  output sdc_pkg::sched_word_t schedule
);
  import sdc_pkg::*;

  localparam int SUM_W = OUT_CW + 1;

  // Stage A signals
  logic        leap0;
  logic        leap1;
  logic [8:0]  len;
  logic [8:0]  cy;
  logic [9:0]  yd;
  logic [13:0] a_year;
  logic        a_leap;
  logic [8:0]  a_yday;

  // Stage 1 registers
  logic        s1_valid;
  logic        s1_month_mode;
  logic [13:0] s1_year;
  logic        s1_leap;
  logic [8:0]  s1_yday;
  logic [3:0]  s1_mon;
  logic [4:0]  s1_mday;
  logic [2:0]  s1_wday;

  // Stage B signals
  logic [3:0]  search_mon;
  logic [3:0]  b_mon;
  logic [4:0]  b_mday;
  logic [14:0] b_p;

  // Stage 2 registers
  logic        s2_valid;
  logic        s2_month_mode;
  logic [13:0] s2_year;
  logic [8:0]  s2_yday;
  logic [3:0]  s2_mon;
  logic [4:0]  s2_mday;
  logic [2:0]  s2_wday;
  logic [14:0] s2_p;
  logic [7:0]  s2_cent;

  // Stage C signals
  logic [14:0] c_dsum;
  logic [29:0] c_prod;

  // Stage 3 registers
  logic        s3_valid;
  logic        s3_month_mode;
  logic [13:0] s3_year;
  logic [8:0]  s3_yday;
  logic [3:0]  s3_mon;
  logic [4:0]  s3_mday;
  logic [2:0]  s3_wday;
  logic [14:0] s3_dsum;
  logic [12:0] s3_q7;

  // Result queue
  sched_word_t       out_mem [OUT_DEPTH];
  logic [OUT_AW-1:0] out_wr_ptr;
  logic [OUT_AW-1:0] out_rd_ptr;
  logic [OUT_CW-1:0] out_count;
  logic              out_rd;
  logic [14:0]       rem7;
  sched_word_t       res_word;
  logic [1:0]        inflight;

  // Issue only when the result queue can absorb every word in flight
  assign inflight = 2'(s1_valid) + 2'(s2_valid) + 2'(s3_valid);
  assign job_pop  = job_valid &&
                    ((SUM_W'(out_count) + SUM_W'(inflight)) < SUM_W'(OUT_DEPTH));

  // Stage A: leap years, final year and day of year
  always_comb begin
    leap0 = is_leap(job.year0, job.cent0);
    leap1 = is_leap(job.year1, job.cent1);
    len   = leap0 ? 9'd366 : 9'd365;
    cy    = (job.cyday >= len) ? len - 9'd1 : job.cyday;
    yd    = 10'(cy) + 10'(job.inc);
    if (job.month_mode) begin
      a_year = job.next_year ? job.year1 : job.year0;
      a_leap = job.next_year ? leap1 : leap0;
      a_yday = month_start(job.mon, a_leap) + 9'(job.mday) - 9'd1;
    end else if (yd >= 10'(len)) begin
      a_year = job.year1;
      a_leap = leap1;
      a_yday = 9'(yd - 10'(len));
    end else begin
      a_year = job.year0;
      a_leap = leap0;
      a_yday = yd[8:0];
    end
  end

  // Stage B: split day of year into month and day, century quotient
  always_comb begin
    search_mon = 4'd0;
    for (int k = 1; k < MONTHS; k++) begin
      if (s1_yday >= month_start(4'(k), s1_leap)) begin
        search_mon = search_mon + 4'd1;
      end
    end
    if (s1_month_mode) begin
      b_mon  = s1_mon;
      b_mday = s1_mday;
    end else begin
      b_mon  = search_mon;
      b_mday = 5'(s1_yday - month_start(search_mon, s1_leap) + 9'd1);
    end
    b_p = 15'(s1_year) + 15'(YEAR_OFFSET);
  end

  // Stage C: day count since the epoch and its quotient by seven
  always_comb begin
    c_dsum = 15'd1 + s2_p + (s2_p >> 2) - 15'(s2_cent) + 15'(s2_cent >> 2)
           + 15'(s2_yday);
    c_prod = 30'(c_dsum) * 30'(DIV7_MUL);
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= job_pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    s1_month_mode <= job.month_mode;
    s1_year       <= a_year;
    s1_leap       <= a_leap;
    s1_yday       <= a_yday;
    s1_mon        <= job.mon;
    s1_mday       <= job.mday;
    s1_wday       <= job.wday;

    s2_month_mode <= s1_month_mode;
    s2_year       <= s1_year;
    s2_yday       <= s1_yday;
    s2_mon        <= b_mon;
    s2_mday       <= b_mday;
    s2_wday       <= s1_wday;
    s2_p          <= b_p;
    s2_cent       <= div100(b_p);

    s3_month_mode <= s2_month_mode;
    s3_year       <= s2_year;
    s3_yday       <= s2_yday;
    s3_mon        <= s2_mon;
    s3_mday       <= s2_mday;
    s3_wday       <= s2_wday;
    s3_dsum       <= c_dsum;
    s3_q7         <= 13'(c_prod >> DIV7_SHIFT);
  end

  // Finish the weekday and form the result word
  always_comb begin
    rem7              = s3_dsum - 15'(s3_q7) * 15'd7;
    res_word.out_year  = s3_year;
    res_word.out_month = s3_mon;
    res_word.out_mday  = s3_mday;
    res_word.out_yday  = s3_yday;
    res_word.out_wday  = s3_month_mode ? rem7[2:0] : s3_wday;
  end

  // Result queue control
  assign out_rd   = pop && !empty;
  assign empty    = (out_count == '0);
  assign schedule = out_mem[out_rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      if (s3_valid) begin
        out_wr_ptr <= out_wr_ptr + OUT_AW'(1);
      end
      if (out_rd) begin
        out_rd_ptr <= out_rd_ptr + OUT_AW'(1);
      end
      if (s3_valid && !out_rd) begin
        out_count <= out_count + OUT_CW'(1);
      end else if (!s3_valid && out_rd) begin
        out_count <= out_count - OUT_CW'(1);
      end
    end
  end

  // Store result words
  always_ff @(posedge clk) begin
    if (s3_valid) begin
      out_mem[out_wr_ptr] <= res_word;
    end
  end

  `SDC_ASSERT(a_credit_bound, (SUM_W'(out_count) + SUM_W'(inflight)) <= SUM_W'(OUT_DEPTH), "result queue credit exceeded")
  `SDC_ASSERT(a_yday_range, !s3_valid || (s3_yday <= 9'd365), "day of year out of range")
  `SDC_ASSERT(a_wday_residue, !(s3_valid && s3_month_mode) || (rem7 < 15'd7), "weekday residue out of range")
  `SDC_ASSERT(a_month_range, !s3_valid || ((s3_mon <= 4'd11) && (s3_mday != 5'd0)), "month or day out of range")

endmodule

`default_nettype wire

>>> rtl/scheduled_date_calculator.sv
// ----------------------------------------------------------------------------
// Scheduled date calculator
// Gregorian date, day of year and weekday of the next requested occurrence.
//
//   Channel   Direction  Handshake           Word
//   request   in         push / full         sdc_pkg::req_word_t
//   schedule  out        pop / empty         sdc_pkg::sched_word_t
//
// Sustains one word per cycle each way unless full or result queue credit
// stalls it; pushed words cross the middle queue and three back-end stages.
// The century quotient and the weekday residue each take one multiply stage.
// rst clears the queues and pipeline valid bits directly; no clearing pass.
// full rises when the four-entry middle queue fills; the back end stops
// issuing once the result queue plus words in flight reach eight.
// ----------------------------------------------------------------------------
`default_nettype none

module scheduled_date_calculator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  sdc_pkg::req_word_t   request,
  input  logic                 pop,
  output logic                 empty,
  output sdc_pkg::sched_word_t schedule
);
  import sdc_pkg::*;

  logic      mid_wr;
  job_word_t mid_wr_word;
  logic      mid_rd;
  job_word_t mid_rd_word;
  logic      mid_empty;

  // Classify incoming words
  sdc_front u_front (
    .request (request),
    .push    (push),
    .full    (full),
    .wr_en   (mid_wr),
    .job     (mid_wr_word)
  );

  // Decouple front end and back end
  sdc_mid_queue u_mid_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_wr),
    .wr_word (mid_wr_word),
    .rd_en   (mid_rd),
    .rd_word (mid_rd_word),
    .full    (full),
    .empty   (mid_empty)
  );

  // Compute dates and queue results
  sdc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!mid_empty),
    .job       (mid_rd_word),
    .job_pop   (mid_rd),
    .pop       (pop),
    .empty     (empty),
    .schedule  (schedule)
  );

endmodule

`default_nettype wire
